### src/gcsh_pkg.sv
`default_nettype none

package gcsh_pkg;

  localparam int PIX_W      = 8;
  localparam int GAIN_W     = 4;
  localparam int BIN_W      = 8;
  localparam int NUM_BINS   = 256;
  localparam int OUT_CNT_W  = 32;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 8;
  localparam int COUNT_BITS_DEF = 32;

  localparam int SUM_W      = PIX_W + 2;
  localparam int DIV3_W     = 20;
  localparam int DIV3_SHIFT = 11;
  localparam logic [DIV3_W-1:0] DIV3_RECIP = 20'd683;

  localparam logic [PIX_W-1:0]  RESET_BLACK_OFFSET = 8'd50;
  localparam logic [GAIN_W-1:0] RESET_GAIN         = 4'd3;
  localparam logic [PIX_W-1:0]  MAX_LEVEL          = 8'd255;

  typedef enum logic {
    OP_PIXEL = 1'b0,
    OP_READ  = 1'b1
  } opcode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BLACK_OFFSET = 8'd0,
    CFG_GAIN         = 8'd1
  } cfg_idx_e;

  typedef struct packed {
    logic                  en;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
  } cfg_wr_t;

  typedef struct packed {
    opcode_e          op;
    logic             inc;
    logic [BIN_W-1:0] addr;
    logic [PIX_W-1:0] bright;
  } item_t;

  typedef struct packed {
    logic [PIX_W-1:0]     brightness;
    logic [OUT_CNT_W-1:0] bin_count;
  } res_t;

endpackage

`default_nettype wire

### src/gcsh_if.sv
`default_nettype none

interface gcsh_pix_if;
  import gcsh_pkg::*;

  logic             valid;
  logic             ready;
  logic             opcode;
  logic [PIX_W-1:0] red;
  logic [PIX_W-1:0] green;
  logic [PIX_W-1:0] blue;
  logic             in_sky;
  logic [BIN_W-1:0] bin_index;

  modport source (output valid, opcode, red, green, blue, in_sky, bin_index, input ready);
  modport sink (input valid, opcode, red, green, blue, in_sky, bin_index, output ready);
endinterface

interface gcsh_res_if;
  import gcsh_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [PIX_W-1:0]     brightness;
  logic [OUT_CNT_W-1:0] bin_count;

  modport source (output valid, brightness, bin_count, input ready);
  modport sink (input valid, brightness, bin_count, output ready);
endinterface

interface gcsh_cfg_if;
  import gcsh_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

### src/gcsh_front.sv
`default_nettype none

module gcsh_front (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  gcsh_pkg::cfg_wr_t           cfg_wr_i,
  input  wire                         load_i,
  input  wire                         opcode_i,
  input  wire [gcsh_pkg::PIX_W-1:0]   red_i,
  input  wire [gcsh_pkg::PIX_W-1:0]   green_i,
  input  wire [gcsh_pkg::PIX_W-1:0]   blue_i,
  input  wire                         in_sky_i,
  input  wire [gcsh_pkg::BIN_W-1:0]   bin_index_i,
  output gcsh_pkg::item_t             item_o
);
  import gcsh_pkg::*;

  logic [PIX_W-1:0]  black_offset_q;
  logic [GAIN_W-1:0] gain_q;

  logic [SUM_W-1:0]  sum;
  logic [DIV3_W-1:0] prod;
  logic [PIX_W-1:0]  grey_d;

  opcode_e           op_q;
  logic              sky_q;
  logic [BIN_W-1:0]  bin_q;
  logic [PIX_W-1:0]  grey_q;

  logic [PIX_W-1:0]        lifted;
  logic [PIX_W+GAIN_W-1:0] scaled;
  logic [PIX_W-1:0]        bright;
  logic                    count;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      black_offset_q <= RESET_BLACK_OFFSET;
      gain_q         <= RESET_GAIN;
    end else if (cfg_wr_i.en) begin
      unique case (cfg_wr_i.index)
        CFG_BLACK_OFFSET: black_offset_q <= cfg_wr_i.data[PIX_W-1:0];
        CFG_GAIN:         gain_q         <= cfg_wr_i.data[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // Division by three as a multiply by a scaled reciprocal; exact for sums up to 765.
  always_comb begin
    sum    = {2'b00, red_i} + {2'b00, green_i} + {2'b00, blue_i};
    prod   = {{(DIV3_W-SUM_W){1'b0}}, sum} * DIV3_RECIP;
    grey_d = prod[DIV3_SHIFT+PIX_W-1:DIV3_SHIFT];
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      op_q   <= opcode_e'(opcode_i);
      sky_q  <= in_sky_i;
      bin_q  <= bin_index_i;
      grey_q <= grey_d;
    end
  end

  always_comb begin
    lifted = (grey_q > black_offset_q) ? (grey_q - black_offset_q) : '0;
    scaled = {{GAIN_W{1'b0}}, lifted} * {{PIX_W{1'b0}}, gain_q};
    bright = (scaled > {{GAIN_W{1'b0}}, MAX_LEVEL}) ? MAX_LEVEL : scaled[PIX_W-1:0];
    count  = (op_q == OP_PIXEL) && sky_q;

    item_o.op     = op_q;
    item_o.inc    = count;
    item_o.addr   = (op_q == OP_READ) ? bin_q : bright;
    item_o.bright = count ? bright : '0;
  end

endmodule

`default_nettype wire

### src/gcsh_hist.sv
`default_nettype none

module gcsh_hist #(
  parameter int COUNT_BITS = gcsh_pkg::COUNT_BITS_DEF
) (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              load_i,
  input  gcsh_pkg::item_t  item_i,
  input  wire              retire_i,
  output gcsh_pkg::res_t   res_o
);
  import gcsh_pkg::*;

  localparam logic [COUNT_BITS-1:0] CntMax = '1;

  logic [COUNT_BITS-1:0] mem_q [NUM_BINS];
  logic [NUM_BINS-1:0]   valid_q;

  item_t                 item_q;
  logic [COUNT_BITS-1:0] rdata_q;
  logic                  rd_valid_q;

  logic                  fwd_valid_q;
  logic [BIN_W-1:0]      fwd_addr_q;
  logic [COUNT_BITS-1:0] fwd_data_q;

  logic [COUNT_BITS-1:0] old_cnt;
  logic [COUNT_BITS-1:0] new_cnt;
  logic [OUT_CNT_W-1:0]  cnt_out;
  logic                  wr_en;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[item_q.addr] <= new_cnt;
    end
    if (load_i) begin
      rdata_q <= mem_q[item_i.addr];
      item_q  <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      rd_valid_q  <= 1'b0;
      fwd_valid_q <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_q[item_q.addr] <= 1'b1;
        fwd_valid_q          <= 1'b1;
      end
      if (load_i) begin
        rd_valid_q <= valid_q[item_i.addr];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      fwd_addr_q <= item_q.addr;
      fwd_data_q <= new_cnt;
    end
  end

  // A write on the same edge as this entry's read is picked up from the bypass.
  always_comb begin
    if (fwd_valid_q && (fwd_addr_q == item_q.addr)) begin
      old_cnt = fwd_data_q;
    end else if (rd_valid_q) begin
      old_cnt = rdata_q;
    end else begin
      old_cnt = '0;
    end
    new_cnt = (old_cnt == CntMax) ? old_cnt : old_cnt + COUNT_BITS'(1);
    wr_en   = retire_i && item_q.inc;
  end

  if (COUNT_BITS >= OUT_CNT_W) begin : g_trunc
    assign cnt_out = old_cnt[OUT_CNT_W-1:0];
  end else begin : g_ext
    assign cnt_out = {{(OUT_CNT_W-COUNT_BITS){1'b0}}, old_cnt};
  end

  always_comb begin
    res_o.brightness = item_q.bright;
    res_o.bin_count  = (item_q.op == OP_READ) ? cnt_out : '0;
  end

endmodule

`default_nettype wire

### src/grey_contrast_stretch_histogram.sv
// Greyscale contrast stretch with a 256-bin brightness histogram.
// The pixel channel carries an opcode, an RGB sample, an in-sky flag and a
// bin index. A sky pixel yields its stretched brightness and counts it in
// its bin; other pixels yield zero. A read yields the count held in a bin.
// Every input transfer produces exactly one result transfer, in order.
// The configuration channel writes the black offset (index 0) and the gain
// (index 1); other indexes are ignored. It is always ready and may be used
// only while the block holds no work.
// Items pass the front, histogram and output registers in turn.
// Throughput is one item per cycle while the receiver is ready: grey
// level, stretch, then a read-modify-write of the bin memory with a
// bypass for consecutive hits on the same bin, and an output register.
// Reset sets the offset to 50 and the gain to 3 and clears all bins at once
// through per-bin valid flags; there is no clearing pass.
// When the receiver stalls, each stage holds its item and the block keeps
// accepting until all three stages are full.
`default_nettype none

module grey_contrast_stretch_histogram #(
  parameter int COUNT_BITS = gcsh_pkg::COUNT_BITS_DEF
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  gcsh_pix_if.sink    pix_i,
  gcsh_res_if.source  res_o,
  gcsh_cfg_if.sink    cfg_i
);
  import gcsh_pkg::*;

  cfg_wr_t cfg_wr;
  item_t   a_item;
  res_t    b_res;
  res_t    c_res_q;

  logic a_v_q;
  logic b_v_q;
  logic c_v_q;
  logic a_rdy;
  logic b_rdy;
  logic c_rdy;
  logic in_xfer;
  logic a_to_b;
  logic b_to_c;

  always_comb begin
    c_rdy   = !c_v_q || res_o.ready;
    b_rdy   = !b_v_q || c_rdy;
    a_rdy   = !a_v_q || b_rdy;
    in_xfer = pix_i.valid && a_rdy;
    a_to_b  = a_v_q && b_rdy;
    b_to_c  = b_v_q && c_rdy;

    cfg_wr.en    = cfg_i.valid;
    cfg_wr.index = cfg_i.index;
    cfg_wr.data  = cfg_i.data;
  end

  assign pix_i.ready      = a_rdy;
  assign cfg_i.ready      = 1'b1;
  assign res_o.valid      = c_v_q;
  assign res_o.brightness = c_res_q.brightness;
  assign res_o.bin_count  = c_res_q.bin_count;

  gcsh_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_wr_i    (cfg_wr),
    .load_i      (in_xfer),
    .opcode_i    (pix_i.opcode),
    .red_i       (pix_i.red),
    .green_i     (pix_i.green),
    .blue_i      (pix_i.blue),
    .in_sky_i    (pix_i.in_sky),
    .bin_index_i (pix_i.bin_index),
    .item_o      (a_item)
  );

  gcsh_hist #(
    .COUNT_BITS (COUNT_BITS)
  ) u_hist (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (a_to_b),
    .item_i   (a_item),
    .retire_i (b_to_c),
    .res_o    (b_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
      b_v_q <= 1'b0;
      c_v_q <= 1'b0;
    end else begin
      if (a_rdy) begin
        a_v_q <= pix_i.valid;
      end
      if (b_rdy) begin
        b_v_q <= a_v_q;
      end
      if (c_rdy) begin
        c_v_q <= b_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_to_c) begin
      c_res_q <= b_res;
    end
  end

  a_result_one_field : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> (res_o.brightness == '0 || res_o.bin_count == '0))
    else $error("result carries both a brightness and a bin count");

  a_accept_fills_front : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pix_i.valid && pix_i.ready) |=> a_v_q)
    else $error("accepted item missing from the front stage");

  a_front_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (a_v_q && !b_rdy) |=> (a_v_q && $stable(a_item)))
    else $error("front stage item changed while stalled");

endmodule

`default_nettype wire
